FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Both forms take a label, the clock,
// the active-low reset and the expression to check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define CRFB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");
// Check that a condition never holds outside reset.
`define CRFB_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CRFB_ASSERT(lbl, clk, rst_n, prop)
`define CRFB_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/core/crfb_pkg.sv
`default_nettype none

package crfb_pkg;

    // Field and storage widths
    localparam int COORD_W     = 12;
    localparam int CFG_W       = 7;
    localparam int PIXEL_W     = 32;
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 6;
    localparam int ROW_W       = 7;
    localparam int SRC_MAX     = 64;

    // Configuration register indexes
    localparam logic CFG_SURF_W = 1'b0;
    localparam logic CFG_SURF_H = 1'b1;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_BLIT  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Frame store access from the sequencer
    typedef struct packed {
        logic               we;
        logic               re;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] wdata;
    } t_mem_req;

endpackage

`default_nettype wire

FILE: rtl/core/crfb_cmd_if.sv
`default_nettype none

interface crfb_cmd_if import crfb_pkg::*; ();
    logic                       valid;
    logic                       ready;
    t_cmd                       command;
    logic signed [COORD_W-1:0]  x_a;
    logic signed [COORD_W-1:0]  y_a;
    logic signed [COORD_W-1:0]  x_b;
    logic signed [COORD_W-1:0]  y_b;
    logic [PIXEL_W-1:0]         color;
    logic                       first;

    modport source (
        output valid, command, x_a, y_a, x_b, y_b, color, first,
        input  ready
    );
    modport sink (
        input  valid, command, x_a, y_a, x_b, y_b, color, first,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/crfb_res_if.sv
`default_nettype none

interface crfb_res_if import crfb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;
    logic               dropped;

    modport source (
        output valid, pixel_value, dropped,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, dropped,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/clipped_rect_fill_and_blit.sv
// Clipped rectangle fill and blit engine over a 64 x 64 frame store of 32-bit
// pixels. Commands arrive on i_cmd (valid/ready); each command returns one
// result item on o_res (valid/ready): the read pixel and a dropped flag.
// Surface width and height are set through the write port (index 0 width,
// index 1 height), only while the engine is idle, a rule for the user that
// the block does not enforce; values clamp to 1..64. One item is worked at
// a time; i_cmd.ready is high only in idle. A command goes from S_SETUP
// through S_BASE to S_FILL, S_BLIT or S_RDREQ and S_RDWAIT, and ends in
// S_DONE. Fill and clear write one pixel per cycle through the single frame
// store write port and pass through S_BASE before each clipped row, where
// the shared multiplier forms the row base address. An empty fill, or a
// read or blit outside the surface, goes from S_SETUP straight to S_DONE.
// The result sits in an output register; a new command is accepted while
// it waits. If the receiver stalls and a second result is ready, the
// engine holds it until the output register frees.
// Reset sets the surface to 64 x 64 and zeroes the blit position; the
// frame store contents stay undefined until written, with no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module clipped_rect_fill_and_blit import crfb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    crfb_cmd_if.sink                i_cmd,
    crfb_res_if.source              o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_BASE,
        S_FILL,
        S_BLIT,
        S_RDREQ,
        S_RDWAIT,
        S_DONE
    } t_state;

    t_state                     r_state;

    // Configuration, stored already clamped
    logic [CFG_W-1:0]           r_eff_w;
    logic [CFG_W-1:0]           r_eff_h;
    logic [CFG_W-1:0]           w_hm1;

    // Latched command
    t_cmd                       r_cmd;
    logic signed [COORD_W-1:0]  r_xa;
    logic signed [COORD_W-1:0]  r_ya;
    logic signed [COORD_W-1:0]  r_xb;
    logic signed [COORD_W-1:0]  r_yb;
    logic [PIXEL_W-1:0]         r_color;
    logic                       r_first;

    // Raster position and bounds
    logic [POS_W-1:0]           r_x;
    logic [POS_W-1:0]           r_x1;
    logic [POS_W:0]             r_x2;
    logic [POS_W-1:0]           r_y;
    logic [POS_W-1:0]           r_y2;
    logic [ADDR_W-1:0]          r_base;
    logic [ADDR_W+POS_W:0]      w_prod;

    // Blit source position
    logic [POS_W-1:0]           r_blit_col;
    logic [ROW_W-1:0]           r_blit_row;

    // Result staging and output register
    logic [PIXEL_W-1:0]         r_pix;
    logic                       r_drop;
    logic                       r_out_valid;
    logic [PIXEL_W-1:0]         r_out_pix;
    logic                       r_out_drop;

    t_mem_req                   w_req;
    logic [PIXEL_W-1:0]         w_rd_data;

    // Fill clipping
    logic signed [COORD_W-1:0]  w_x1;
    logic signed [COORD_W-1:0]  w_x2;
    logic signed [COORD_W-1:0]  w_y1;
    logic signed [COORD_W-1:0]  w_y2;
    logic                       w_fill_empty;

    // Blit placement
    logic [POS_W-1:0]           w_col;
    logic [ROW_W-1:0]           w_row;
    logic [ROW_W-1:0]           w_sw;
    logic [ROW_W-1:0]           w_sh;
    logic                       w_src_out;
    logic signed [COORD_W:0]    w_tx;
    logic signed [COORD_W:0]    w_ty;
    logic                       w_tgt_in;
    logic [ROW_W-1:0]           w_col_nx;

    logic                       w_rd_in;

    function automatic logic [CFG_W-1:0] f_clamp_dim(
        input logic [CFG_W-1:0] v,
        input logic [CFG_W-1:0] hi
    );
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= CFG_W'(MAX_WIDTH);
            r_eff_h <= CFG_W'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SURF_W: r_eff_w <= f_clamp_dim(i_cfg_data, CFG_W'(MAX_WIDTH));
                CFG_SURF_H: r_eff_h <= f_clamp_dim(i_cfg_data, CFG_W'(MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    assign w_hm1 = r_eff_h - CFG_W'(1);

    // Clip the fill rectangle
    assign w_x1 = r_xa[COORD_W-1] ? '0 : r_xa;
    assign w_y1 = r_ya[COORD_W-1] ? '0 : r_ya;
    assign w_x2 = (r_xb > $signed(COORD_W'(r_eff_w))) ? $signed(COORD_W'(r_eff_w)) : r_xb;
    assign w_y2 = (r_yb > $signed(COORD_W'(w_hm1))) ? $signed(COORD_W'(w_hm1)) : r_yb;
    assign w_fill_empty = (w_y1 > w_y2) || (w_x1 >= w_x2);

    // Place the blit pixel
    assign w_col = r_first ? '0 : r_blit_col;
    assign w_row = r_first ? '0 : r_blit_row;
    assign w_sw  = r_xb[COORD_W-1] ? '0 :
                   (r_xb > $signed(COORD_W'(SRC_MAX))) ? ROW_W'(SRC_MAX) : r_xb[ROW_W-1:0];
    assign w_sh  = r_yb[COORD_W-1] ? '0 :
                   (r_yb > $signed(COORD_W'(SRC_MAX))) ? ROW_W'(SRC_MAX) : r_yb[ROW_W-1:0];
    assign w_src_out = (w_sw == '0) || (w_row >= w_sh);
    assign w_tx = $signed({r_xa[COORD_W-1], r_xa} + (COORD_W+1)'(w_col));
    assign w_ty = $signed({r_ya[COORD_W-1], r_ya} + (COORD_W+1)'(w_row));
    assign w_tgt_in = !w_tx[COORD_W] && (w_tx < $signed((COORD_W+1)'(r_eff_w)))
                   && !w_ty[COORD_W] && (w_ty < $signed((COORD_W+1)'(r_eff_h)));
    assign w_col_nx = ROW_W'(w_col) + ROW_W'(1);

    // Check the read position
    assign w_rd_in = !r_xa[COORD_W-1] && (r_xa < $signed(COORD_W'(r_eff_w)))
                  && !r_ya[COORD_W-1] && (r_ya < $signed(COORD_W'(r_eff_h)));

    // Shared row base multiplier and address adder
    assign w_prod = (ADDR_W+POS_W+1)'(r_y) * (ADDR_W+POS_W+1)'(r_eff_w);

    always_comb begin
        w_req.we    = (r_state == S_FILL) || (r_state == S_BLIT);
        w_req.re    = (r_state == S_RDREQ);
        w_req.addr  = r_base + ADDR_W'(r_x);
        w_req.wdata = r_color;
    end

    crfb_frame_mem u_frame_mem (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    // Sequence each command and hold its result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_blit_col  <= '0;
            r_blit_row  <= '0;
        end else begin
            if (r_out_valid && o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.command;
                        r_xa    <= i_cmd.x_a;
                        r_ya    <= i_cmd.y_a;
                        r_xb    <= i_cmd.x_b;
                        r_yb    <= i_cmd.y_b;
                        r_color <= i_cmd.color;
                        r_first <= i_cmd.first;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_pix  <= '0;
                    r_drop <= (r_cmd == CMD_BLIT) && (w_src_out || !w_tgt_in);
                    case (r_cmd)
                        CMD_CLEAR: begin
                            r_x     <= '0;
                            r_x1    <= '0;
                            r_x2    <= r_eff_w;
                            r_y     <= '0;
                            r_y2    <= w_hm1[POS_W-1:0];
                            r_state <= S_BASE;
                        end
                        CMD_FILL: begin
                            r_x  <= w_x1[POS_W-1:0];
                            r_x1 <= w_x1[POS_W-1:0];
                            r_x2 <= w_x2[POS_W:0];
                            r_y  <= w_y1[POS_W-1:0];
                            r_y2 <= w_y2[POS_W-1:0];
                            r_state <= w_fill_empty ? S_DONE : S_BASE;
                        end
                        CMD_BLIT: begin
                            if (w_src_out) begin
                                r_blit_col <= w_col;
                                r_blit_row <= w_row;
                                r_state    <= S_DONE;
                            end else begin
                                // Advance the source position, row saturates
                                if (w_col_nx >= w_sw) begin
                                    r_blit_col <= '0;
                                    r_blit_row <= (w_row < ROW_W'(SRC_MAX)) ?
                                                  w_row + ROW_W'(1) : w_row;
                                end else begin
                                    r_blit_col <= w_col_nx[POS_W-1:0];
                                    r_blit_row <= w_row;
                                end
                                r_x <= w_tx[POS_W-1:0];
                                r_y <= w_ty[POS_W-1:0];
                                r_state <= w_tgt_in ? S_BASE : S_DONE;
                            end
                        end
                        CMD_READ: begin
                            r_x     <= r_xa[POS_W-1:0];
                            r_y     <= r_ya[POS_W-1:0];
                            r_state <= w_rd_in ? S_BASE : S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_BASE: begin
                    r_base <= w_prod[ADDR_W-1:0];
                    case (r_cmd)
                        CMD_CLEAR: r_state <= S_FILL;
                        CMD_FILL:  r_state <= S_FILL;
                        CMD_BLIT:  r_state <= S_BLIT;
                        CMD_READ:  r_state <= S_RDREQ;
                        default:   r_state <= S_DONE;
                    endcase
                end
                S_FILL: begin
                    // Step along the row, then to the next row base
                    if ((POS_W+1)'(r_x) + (POS_W+1)'(1) == r_x2) begin
                        if (r_y == r_y2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_x     <= r_x1;
                            r_y     <= r_y + POS_W'(1);
                            r_state <= S_BASE;
                        end
                    end else begin
                        r_x <= r_x + POS_W'(1);
                    end
                end
                S_BLIT: begin
                    r_state <= S_DONE;
                end
                S_RDREQ: begin
                    r_state <= S_RDWAIT;
                end
                S_RDWAIT: begin
                    r_pix   <= w_rd_data;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pix   <= r_pix;
                        r_out_drop  <= r_drop;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE) && i_rst_n;
    assign o_res.valid       = r_out_valid;
    assign o_res.pixel_value = r_out_pix;
    assign o_res.dropped     = r_out_drop;

    `CRFB_ASSERT(a_accept_setup, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready |=> r_state == S_SETUP)
    `CRFB_ASSERT(a_fill_bounds, i_clk, i_rst_n, r_state == S_FILL |-> (((POS_W+1)'(r_x) < r_x2) && (r_y <= r_y2)))
    `CRFB_NEVER(a_drop_no_pixel, i_clk, i_rst_n, r_out_valid && r_out_drop && (r_out_pix != '0))
    `CRFB_NEVER(a_row_saturates, i_clk, i_rst_n, r_blit_row > ROW_W'(SRC_MAX))

endmodule

`default_nettype wire

FILE: rtl/core/crfb_frame_mem.sv
`default_nettype none

module crfb_frame_mem import crfb_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_mem_req           i_req,
    output logic [PIXEL_W-1:0]      o_rd_data
);

    logic [PIXEL_W-1:0] r_mem [STORE_DEPTH];
    logic [PIXEL_W-1:0] r_rd_data;

    // Write one pixel, read one pixel with registered data
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: verif/tb_clipped_rect_fill_and_blit.sv
`timescale 1ns / 100ps

module tb_clipped_rect_fill_and_blit;
    import crfb_pkg::*;

    // One command item as seen on the command channel
    typedef struct {
        t_cmd                       command;
        logic signed [COORD_W-1:0]  x_a;
        logic signed [COORD_W-1:0]  y_a;
        logic signed [COORD_W-1:0]  x_b;
        logic signed [COORD_W-1:0]  y_b;
        logic [PIXEL_W-1:0]         color;
        logic                       first;
    } t_draw_cmd;

    // One result item: read pixel and dropped flag
    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               dropped;
    } t_draw_result;

    // Mirror of the frame store, blit position and surface size
    class t_frame_tracker;
        logic [PIXEL_W-1:0] pixels [STORE_DEPTH];
        logic [POS_W-1:0]   blit_col;
        logic [ROW_W-1:0]   blit_row;
        logic [CFG_W-1:0]   reg_w;
        logic [CFG_W-1:0]   reg_h;
        t_draw_result       due_results[$];
        int                 cmd_count[4];
        int                 drop_count;
        int                 err_count;

        function new();
            blit_col   = '0;
            blit_row   = '0;
            reg_w      = CFG_W'(MAX_WIDTH);
            reg_h      = CFG_W'(MAX_HEIGHT);
            drop_count = 0;
            err_count  = 0;
            foreach (cmd_count[i]) cmd_count[i] = 0;
        endfunction

        function int clamp_int(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == CFG_SURF_W) reg_w = val;
            else reg_h = val;
        endfunction

        // Apply one accepted command and queue the result it must give
        function void note_command(t_draw_cmd it);
            int           w, h, xa, ya, xb, yb;
            int           y1, y2, x1, x2, sw, sh, tx, ty;
            t_draw_result r;
            w  = clamp_int(int'(reg_w), 1, MAX_WIDTH);
            h  = clamp_int(int'(reg_h), 1, MAX_HEIGHT);
            xa = it.x_a;
            ya = it.y_a;
            xb = it.x_b;
            yb = it.y_b;
            r.pixel   = '0;
            r.dropped = 1'b0;
            cmd_count[int'(it.command)]++;
            case (it.command)
                CMD_CLEAR: begin
                    for (int y = 0; y < h; y++)
                        for (int x = 0; x < w; x++)
                            pixels[y * w + x] = it.color;
                end
                CMD_FILL: begin
                    // rows inclusive, columns end-exclusive, both clipped
                    y1 = (ya < 0) ? 0 : ya;
                    y2 = (yb > h - 1) ? h - 1 : yb;
                    x1 = (xa < 0) ? 0 : xa;
                    x2 = (xb > w) ? w : xb;
                    for (int y = y1; y <= y2; y++)
                        for (int x = x1; x < x2; x++)
                            pixels[y * w + x] = it.color;
                end
                CMD_BLIT: begin
                    sw = clamp_int(xb, 0, SRC_MAX);
                    sh = clamp_int(yb, 0, SRC_MAX);
                    if (it.first) begin
                        blit_col = '0;
                        blit_row = '0;
                    end
                    if (sw == 0 || int'(blit_row) >= sh) begin
                        // outside the source: hold the position
                        r.dropped = 1'b1;
                    end else begin
                        tx = xa + int'(blit_col);
                        ty = ya + int'(blit_row);
                        if (tx >= 0 && tx < w && ty >= 0 && ty < h)
                            pixels[ty * w + tx] = it.color;
                        else
                            r.dropped = 1'b1;
                        // advance row-major, row saturates at the source limit
                        if (int'(blit_col) + 1 >= sw) begin
                            blit_col = '0;
                            if (int'(blit_row) < SRC_MAX) blit_row = blit_row + 1'b1;
                        end else begin
                            blit_col = blit_col + 1'b1;
                        end
                    end
                end
                default: begin
                    if (xa >= 0 && xa < w && ya >= 0 && ya < h)
                        r.pixel = pixels[ya * w + xa];
                end
            endcase
            due_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [PIXEL_W-1:0] got,
                             logic [PIXEL_W-1:0] want);
            err_count++;
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        endtask

        // Compare a result item with the oldest expectation
        task check_result(logic [PIXEL_W-1:0] pix, logic drop);
            t_draw_result want;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", pix, {31'd0, drop});
                return;
            end
            want = due_results.pop_front();
            if (pix !== want.pixel) report_mismatch("pixel_value", pix, want.pixel);
            if (drop !== want.dropped)
                report_mismatch("dropped", {31'd0, drop}, {31'd0, want.dropped});
            if (want.dropped) drop_count++;
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 surf_w;
    int                 surf_h;
    t_frame_tracker     tracker;

    crfb_cmd_if cmd_if ();
    crfb_res_if res_if ();

    clipped_rect_fill_and_blit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watch both channels: predict on accept, check on result
    always @(posedge i_clk) begin : watch
        t_draw_cmd seen;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                seen.command = cmd_if.command;
                seen.x_a     = cmd_if.x_a;
                seen.y_a     = cmd_if.y_a;
                seen.x_b     = cmd_if.x_b;
                seen.y_b     = cmd_if.y_b;
                seen.color   = cmd_if.color;
                seen.first   = cmd_if.first;
                tracker.note_command(seen);
            end
            if (res_if.valid && res_if.ready)
                tracker.check_result(res_if.pixel_value, res_if.dropped);
        end
    end

    function automatic int rnd_coord();
        return int'($urandom_range(4095)) - 2048;
    endfunction

    // Present one item, idling first at random, and hold it until accepted
    task automatic send_cmd(input t_cmd c, input int xa, input int ya, input int xb,
                            input int yb, input logic [PIXEL_W-1:0] col, input logic fst);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= c;
        cmd_if.x_a     <= COORD_W'(xa);
        cmd_if.y_a     <= COORD_W'(ya);
        cmd_if.x_b     <= COORD_W'(xb);
        cmd_if.y_b     <= COORD_W'(yb);
        cmd_if.color   <= col;
        cmd_if.first   <= fst;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every result is back and the engine is quiet
    task automatic settle();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both surface registers on back-to-back edges
    task automatic configure(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SURF_W;
        i_cfg_data <= w_raw;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SURF_H;
        i_cfg_data <= h_raw;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_reg(CFG_SURF_W, w_raw);
        tracker.set_reg(CFG_SURF_H, h_raw);
        surf_w = tracker.clamp_int(int'(w_raw), 1, MAX_WIDTH);
        surf_h = tracker.clamp_int(int'(h_raw), 1, MAX_HEIGHT);
    endtask

    // One blit: a first pixel then a stream with the same origin and size
    task automatic blit_run(output int n_sent);
        int xa, ya, xb, yb, sw, sh, len;
        if ($urandom_range(9) < 8) xb = $urandom_range(1, 5);
        else case ($urandom_range(2))
            0: xb = 0;
            1: xb = -int'($urandom_range(1, 2048));
            default: xb = $urandom_range(65, 2047);
        endcase
        if ($urandom_range(9) < 8) yb = $urandom_range(1, 4);
        else case ($urandom_range(2))
            0: yb = 0;
            1: yb = -int'($urandom_range(1, 2048));
            default: yb = $urandom_range(65, 2047);
        endcase
        if ($urandom_range(9) == 0) begin
            xa = rnd_coord();
            ya = rnd_coord();
        end else begin
            xa = int'($urandom_range(surf_w + 2)) - 3;
            ya = int'($urandom_range(surf_h + 2)) - 3;
        end
        sw  = tracker.clamp_int(xb, 0, SRC_MAX);
        sh  = tracker.clamp_int(yb, 0, SRC_MAX);
        len = sw * sh;
        if (len > 16) len = $urandom_range(6, 16);
        if (len == 0) len = $urandom_range(1, 3);
        // cut some sequences short, overrun others past the source end
        if ($urandom_range(9) == 0) len = $urandom_range(1, len);
        else len = len + int'($urandom_range(2));
        for (int i = 0; i < len; i++)
            send_cmd(CMD_BLIT, xa, ya, xb, yb, $urandom, (i == 0));
        n_sent = len;
    endtask

    // Mixed random traffic, mostly well-formed blit streams
    task automatic run_random(input int n_items);
        int sent, k, r, xa, ya, xb, yb;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 3) begin
                send_cmd(CMD_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         $urandom, 1'($urandom_range(1)));
                sent++;
            end else if (r < 20) begin
                if ($urandom_range(9) < 7) begin
                    xa = int'($urandom_range(surf_w + 2)) - 3;
                    xb = xa + int'($urandom_range(6));
                    ya = int'($urandom_range(surf_h + 2)) - 2;
                    yb = ya + int'($urandom_range(5)) - 1;
                end else begin
                    xa = rnd_coord();
                    xb = rnd_coord();
                    ya = rnd_coord();
                    yb = rnd_coord();
                end
                send_cmd(CMD_FILL, xa, ya, xb, yb, $urandom, 1'($urandom_range(1)));
                sent++;
            end else if (r < 35) begin
                if ($urandom_range(99) < 85) begin
                    xa = $urandom_range(surf_w - 1);
                    ya = $urandom_range(surf_h - 1);
                end else begin
                    xa = rnd_coord();
                    ya = rnd_coord();
                end
                send_cmd(CMD_READ, xa, ya, rnd_coord(), rnd_coord(), $urandom,
                         1'($urandom_range(1)));
                sent++;
            end else if (r < 85) begin
                blit_run(k);
                sent += k;
            end else begin
                // stray blit pixel with arbitrary fields
                send_cmd(CMD_BLIT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         $urandom, 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // New surface, a clear so every pixel in use is defined, then traffic
    task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                             input int idle_pct, input int stall_pct, input int n_items);
        configure(w_raw, h_raw);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, $urandom, 1'b0);
        run_random(n_items);
        settle();
    endtask

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        tracker = new();
        surf_w  = MAX_WIDTH;
        surf_h  = MAX_HEIGHT;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_SURF_W;
        i_cfg_data     <= '0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_CLEAR;
        cmd_if.x_a     <= '0;
        cmd_if.y_a     <= '0;
        cmd_if.x_b     <= '0;
        cmd_if.y_b     <= '0;
        cmd_if.color   <= '0;
        cmd_if.first   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full clear, fill clipping at the coordinate extremes
        send_cmd(CMD_CLEAR, 0, 0, 0, 0, 32'h0000_0000, 1'b0);
        send_cmd(CMD_FILL, -2048, -2048, 2047, 2047, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_FILL, 10, 0, 10, 63, 32'h1111_1111, 1'b0);
        send_cmd(CMD_FILL, 0, 20, 64, 5, 32'h2222_2222, 1'b0);
        send_cmd(CMD_FILL, 3, 2, 8, 4, 32'hA5A5_5A5A, 1'b0);
        // reads inside, on the exclusive right edge, and outside the surface
        send_cmd(CMD_READ, 3, 2, 0, 0, 32'h0, 1'b0);
        send_cmd(CMD_READ, 7, 4, 0, 0, 32'h0, 1'b0);
        send_cmd(CMD_READ, 8, 2, 0, 0, 32'h0, 1'b0);
        send_cmd(CMD_READ, 63, 63, 0, 0, 32'h0, 1'b0);
        send_cmd(CMD_READ, -1, 0, 0, 0, 32'h0, 1'b0);
        send_cmd(CMD_READ, 64, 0, 0, 0, 32'h0, 1'b0);
        send_cmd(CMD_READ, 0, 64, 0, 0, 32'h0, 1'b0);
        send_cmd(CMD_READ, 2047, -2048, 0, 0, 32'h0, 1'b0);
        // blits with an empty source
        send_cmd(CMD_BLIT, 5, 5, 0, 3, 32'h0102_0304, 1'b1);
        send_cmd(CMD_BLIT, 5, 5, -2048, -2048, 32'h0506_0708, 1'b1);
        // 3 x 2 source hanging off the right edge, then one past its end
        for (int i = 0; i < 7; i++)
            send_cmd(CMD_BLIT, 62, 5, 3, 2, 32'hC0DE_0000 + i, (i == 0));
        send_cmd(CMD_READ, 63, 6, 0, 0, 32'h0, 1'b0);
        // negative origin clips the first column only
        send_cmd(CMD_BLIT, -1, 0, 2, 1, 32'hBEEF_0001, 1'b1);
        send_cmd(CMD_BLIT, -1, 0, 2, 1, 32'hBEEF_0002, 1'b0);
        send_cmd(CMD_READ, 0, 0, 0, 0, 32'h0, 1'b0);
        settle();

        // Random phases over register extremes and idling patterns
        run_phase(7'd127, 7'd0, 85, 0, 22);
        run_phase(7'd0, 7'd127, 0, 85, 22);
        run_phase(CFG_W'($urandom_range(2, 63)), CFG_W'($urandom_range(2, 63)), 8, 8, 22);
        run_phase(7'd64, 7'd64, 0, 0, 22);
        run_phase(7'd1, 7'd1, 0, 85, 22);

        $display("Covered %0d clears, %0d fills, %0d blit pixels and %0d reads on six surfaces",
                 tracker.cmd_count[CMD_CLEAR], tracker.cmd_count[CMD_FILL],
                 tracker.cmd_count[CMD_BLIT], tracker.cmd_count[CMD_READ]);
        $display("Dropped blit pixels seen: %0d, mismatches: %0d",
                 tracker.drop_count, tracker.err_count);
        if (tracker.err_count == 0 && tracker.due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: clipped_rect_fill_and_blit.f
+incdir+rtl/core
rtl/core/crfb_pkg.sv
rtl/core/crfb_cmd_if.sv
rtl/core/crfb_res_if.sv
rtl/core/crfb_frame_mem.sv
rtl/core/clipped_rect_fill_and_blit.sv
verif/tb_clipped_rect_fill_and_blit.sv
